[hdl/bdq_pkg.sv]
package bdq_pkg;

	localparam int DATA_W = 32;

	// operation codes carried by the kind field
	typedef enum logic [2:0] {
		KIND_INS_FRONT = 3'd0,
		KIND_INS_REAR  = 3'd1,
		KIND_DEL_FRONT = 3'd2,
		KIND_DEL_REAR  = 3'd3,
		KIND_INS_ORD   = 3'd4,
		KIND_DUMP      = 3'd5
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// what the cell row does this cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INS_FRONT,
		CELL_INS_REAR,
		CELL_INS_ORD,
		CELL_DEL_FRONT,
		CELL_DEL_REAR,
		CELL_ROTATE
	} cell_op_t;

	// source of the result value
	typedef enum logic [1:0] {
		OUT_ZERO,
		OUT_FRONT,
		OUT_REAR
	} out_sel_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	// controller to datapath
	typedef struct packed {
		cell_op_t cell_op;
		logic     out_load;
		out_sel_t out_sel;
		status_t  out_status;
		logic     out_last;
		logic     rem_load;
		logic     rem_dec;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic single;
		logic rem_one;
		logic out_valid;
	} stat_t;

endpackage

[hdl/bdq_ctrl.sv]
module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        kind,
	input  logic              out_stall,
	input  bdq_pkg::stat_t    stat,
	output bdq_pkg::cmd_t     cmd
);

	bdq_pkg::state_t state_q, state_nxt;
	logic            out_free;
	logic            fire;

	// output register can take a new transaction this cycle
	assign out_free = !stat.out_valid || !out_stall;
	assign fire     = (state_q == bdq_pkg::ST_IDLE) && in_valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				if (fire && kind == bdq_pkg::KIND_DUMP && !stat.empty && !stat.single) begin
					state_nxt = bdq_pkg::ST_DUMP;
				end
			end
			bdq_pkg::ST_DUMP: begin
				if (out_free && stat.rem_one) begin
					state_nxt = bdq_pkg::ST_IDLE;
				end
			end
			default: state_nxt = bdq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall       = 1'b1;
		cmd.cell_op    = bdq_pkg::CELL_HOLD;
		cmd.out_load   = 1'b0;
		cmd.out_sel    = bdq_pkg::OUT_ZERO;
		cmd.out_status = bdq_pkg::STAT_OK;
		cmd.out_last   = 1'b1;
		cmd.rem_load   = 1'b0;
		cmd.rem_dec    = 1'b0;
		unique case (state_q)
			bdq_pkg::ST_IDLE: begin
				in_stall = !out_free;
				if (fire) begin
					case (kind) inside
						bdq_pkg::KIND_INS_FRONT, bdq_pkg::KIND_INS_REAR,
						bdq_pkg::KIND_INS_ORD: begin
							cmd.out_load = 1'b1;
							if (stat.full) begin
								cmd.out_status = bdq_pkg::STAT_FULL;
							end else if (kind == bdq_pkg::KIND_INS_FRONT) begin
								cmd.cell_op = bdq_pkg::CELL_INS_FRONT;
							end else if (kind == bdq_pkg::KIND_INS_REAR) begin
								cmd.cell_op = bdq_pkg::CELL_INS_REAR;
							end else begin
								cmd.cell_op = bdq_pkg::CELL_INS_ORD;
							end
						end
						bdq_pkg::KIND_DEL_FRONT: begin
							cmd.out_load = 1'b1;
							if (stat.empty) begin
								cmd.out_status = bdq_pkg::STAT_EMPTY;
							end else begin
								cmd.cell_op = bdq_pkg::CELL_DEL_FRONT;
								cmd.out_sel = bdq_pkg::OUT_FRONT;
							end
						end
						bdq_pkg::KIND_DEL_REAR: begin
							cmd.out_load = 1'b1;
							if (stat.empty) begin
								cmd.out_status = bdq_pkg::STAT_EMPTY;
							end else begin
								cmd.cell_op = bdq_pkg::CELL_DEL_REAR;
								cmd.out_sel = bdq_pkg::OUT_REAR;
							end
						end
						bdq_pkg::KIND_DUMP: begin
							cmd.out_load = 1'b1;
							if (stat.empty) begin
								cmd.out_status = bdq_pkg::STAT_EMPTY;
							end else begin
								cmd.cell_op  = bdq_pkg::CELL_ROTATE;
								cmd.out_sel  = bdq_pkg::OUT_FRONT;
								cmd.out_last = stat.single;
								cmd.rem_load = 1'b1;
							end
						end
						default: begin
							// unused codes are swallowed without a result
						end
					endcase
				end
			end
			bdq_pkg::ST_DUMP: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.cell_op  = bdq_pkg::CELL_ROTATE;
					cmd.out_sel  = bdq_pkg::OUT_FRONT;
					cmd.out_last = stat.rem_one;
					cmd.rem_dec  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hdl/bdq_datapath.sv]
module bdq_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [bdq_pkg::DATA_W-1:0]  value,
	input  bdq_pkg::cmd_t                      cmd,
	output bdq_pkg::stat_t                     stat,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [1:0]                         status,
	output logic signed [bdq_pkg::DATA_W-1:0]  result_value,
	output logic                               last
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic signed [bdq_pkg::DATA_W-1:0] cells_q [DEPTH];
	logic signed [bdq_pkg::DATA_W-1:0] cells_nxt [DEPTH];
	logic signed [bdq_pkg::DATA_W-1:0] up_val [DEPTH];
	logic signed [bdq_pkg::DATA_W-1:0] dn_val [DEPTH];
	logic [bdq_pkg::DATA_W-1:0]        rear_terms [DEPTH];
	logic [bdq_pkg::DATA_W-1:0]        rear_val;
	logic [CntW-1:0]                   count_q;
	logic [CntW-1:0]                   rem_q;
	logic [DEPTH-1:0]                  below_cnt;
	logic [DEPTH-1:0]                  is_rear;
	logic [DEPTH-1:0]                  lt;
	logic [DEPTH-1:0]                  before_ord;
	logic [DEPTH-1:0]                  stay;
	logic [DEPTH-1:0]                  at_pos;
	logic                              out_valid_q;
	bdq_pkg::status_t                  status_q;
	logic signed [bdq_pkg::DATA_W-1:0] result_q;
	logic                              last_q;

	// per-cell compare and neighbour taps
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [DEPTH-1:0] LowMask = {DEPTH{1'b1}} >> (DEPTH - 1 - i);

		assign below_cnt[i] = CntW'(i) < count_q;
		assign is_rear[i]   = CntW'(i + 1) == count_q;
		assign lt[i]        = below_cnt[i] && (cells_q[i] < value);
		// every cell up to this one holds a smaller value
		assign before_ord[i] = &(lt | ~LowMask);
		assign rear_terms[i] = is_rear[i] ? cells_q[i] : '0;

		if (i < DEPTH - 1) begin : g_up
			assign up_val[i] = cells_q[i + 1];
		end else begin : g_up_end
			assign up_val[i] = cells_q[i];
		end

		if (i > 0) begin : g_dn
			assign dn_val[i] = cells_q[i - 1];
			assign at_pos[i] = stay[i - 1] && !stay[i];
		end else begin : g_dn_first
			assign dn_val[i] = cells_q[i];
			assign at_pos[i] = !stay[i];
		end

		// next value of this cell
		always_comb begin
			cells_nxt[i] = cells_q[i];
			case (cmd.cell_op) inside
				bdq_pkg::CELL_INS_FRONT, bdq_pkg::CELL_INS_REAR,
				bdq_pkg::CELL_INS_ORD: begin
					if (at_pos[i]) begin
						cells_nxt[i] = value;
					end else if (!stay[i]) begin
						cells_nxt[i] = dn_val[i];
					end
				end
				bdq_pkg::CELL_DEL_FRONT: cells_nxt[i] = up_val[i];
				bdq_pkg::CELL_ROTATE: begin
					if (is_rear[i]) begin
						cells_nxt[i] = cells_q[0];
					end else if (below_cnt[i]) begin
						cells_nxt[i] = up_val[i];
					end
				end
				default: begin
				end
			endcase
		end

		always_ff @(posedge clk) begin
			cells_q[i] <= cells_nxt[i];
		end
	end

	// insert position as a thermometer of cells that stay put
	always_comb begin
		case (cmd.cell_op)
			bdq_pkg::CELL_INS_REAR: stay = below_cnt;
			bdq_pkg::CELL_INS_ORD:  stay = before_ord;
			default:                stay = '0;
		endcase
	end

	// rear entry select
	always_comb begin
		rear_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_val = rear_val | rear_terms[i];
		end
	end

	// entry count and dump countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			case (cmd.cell_op) inside
				bdq_pkg::CELL_INS_FRONT, bdq_pkg::CELL_INS_REAR,
				bdq_pkg::CELL_INS_ORD: count_q <= count_q + CntW'(1);
				bdq_pkg::CELL_DEL_FRONT, bdq_pkg::CELL_DEL_REAR:
					count_q <= count_q - CntW'(1);
				default: begin
				end
			endcase
			if (cmd.rem_load) begin
				rem_q <= count_q - CntW'(1);
			end else if (cmd.rem_dec) begin
				rem_q <= rem_q - CntW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			last_q   <= cmd.out_last;
			case (cmd.out_sel)
				bdq_pkg::OUT_FRONT: result_q <= cells_q[0];
				bdq_pkg::OUT_REAR:  result_q <= rear_val;
				default:            result_q <= '0;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign last         = last_q;

	assign stat.empty     = count_q == '0;
	assign stat.full      = count_q == CntW'(DEPTH);
	assign stat.single    = count_q == CntW'(1);
	assign stat.rem_one   = rem_q == CntW'(1);
	assign stat.out_valid = out_valid_q;

endmodule

[hdl/bounded_deque_with_sorted_insert_top.sv]
// Bounded deque of up to DEPTH signed 32-bit entries with ordered insert.
// kind selects insert front, insert rear, delete front, delete rear,
// ordered insert (before the first entry not less than value, else at the
// rear) or dump. Every operation gives one result, except dump of a
// non-empty list, which gives one result per entry, front first, with last
// set on the final one; unused kind codes are taken and give no result.
// Inserts into a full list are dropped with status full; deletes and dumps
// of an empty list report status empty. The entries sit in a row of cells
// that compare and shift in parallel, and the result of an operation is
// registered and valid the cycle after it is taken; a dump holds the input
// stalled after it is taken until its last entry is loaded, while the row
// rotates one entry a cycle past the output register whenever the output is
// not stalled. The output register lets a new transaction be taken in the
// same cycle the previous result leaves.
module bounded_deque_with_sorted_insert_top #(
	parameter int DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         kind,
	input  logic signed [bdq_pkg::DATA_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic signed [bdq_pkg::DATA_W-1:0]  result_value,
	output logic                               last
);

	bdq_pkg::cmd_t  cmd;
	bdq_pkg::stat_t stat;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	bdq_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.cmd          (cmd),
		.stat         (stat),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.result_value (result_value),
		.last         (last)
	);

endmodule
